@@ design/hmi_pkg.sv @@
`default_nettype none

package hmi_pkg;

  // Field widths of one moment and of one invariant.
  localparam int IN_W  = 32;
  localparam int OUT_W = 64;

  // Default fixed-point formats: inputs Q2.30, results Q8.56.
  localparam int IN_FRAC_DEFAULT  = 30;
  localparam int OUT_FRAC_DEFAULT = 56;

  // Load enables of the two register stages inside a split multiplier.
  typedef struct packed {
    logic pp;
    logic sum;
  } mul_en_t;

endpackage

`default_nettype wire

@@ design/hmi_wmul.sv @@
`default_nettype none

// Wide signed multiplier cut into four partial products.
// The first register stage holds the partial products, the second the sum.
module hmi_wmul #(
  parameter int A_W = 32,
  parameter int B_W = 32
) (
  input  logic                        clk_i,
  input  hmi_pkg::mul_en_t            en_i,
  input  logic signed [A_W-1:0]       a_i,
  input  logic signed [B_W-1:0]       b_i,
  output logic signed [A_W+B_W-1:0]   p_o
);

  localparam int ALW = A_W / 2;
  localparam int AHW = A_W - ALW;
  localparam int BLW = B_W / 2;
  localparam int BHW = B_W - BLW;
  localparam int P_W = A_W + B_W;

  logic signed [AHW-1:0] ah;
  logic signed [ALW:0]   al;
  logic signed [BHW-1:0] bh;
  logic signed [BLW:0]   bl;

  logic signed [AHW+BHW-1:0] pp_hh_d, pp_hh_q;
  logic signed [AHW+BLW:0]   pp_hl_d, pp_hl_q;
  logic signed [ALW+BHW:0]   pp_lh_d, pp_lh_q;
  logic signed [ALW+BLW+1:0] pp_ll_d, pp_ll_q;
  logic signed [P_W-1:0]     p_d, p_q;

  // Upper halves keep the sign, lower halves are unsigned with a zero on top.
  assign ah = a_i[A_W-1:ALW];
  assign al = {1'b0, a_i[ALW-1:0]};
  assign bh = b_i[B_W-1:BLW];
  assign bl = {1'b0, b_i[BLW-1:0]};

  // Partial products, each about half by half wide.
  assign pp_hh_d = ah * bh;
  assign pp_hl_d = ah * bl;
  assign pp_lh_d = al * bh;
  assign pp_ll_d = al * bl;

  always_ff @(posedge clk_i) begin
    if (en_i.pp) begin
      pp_hh_q <= pp_hh_d;
      pp_hl_q <= pp_hl_d;
      pp_lh_q <= pp_lh_d;
      pp_ll_q <= pp_ll_d;
    end
  end

  // Align and add the partial products; the exact product fits in P_W bits.
  assign p_d = (P_W'(pp_hh_q) <<< (ALW + BLW)) + (P_W'(pp_hl_q) <<< ALW)
             + (P_W'(pp_lh_q) <<< BLW) + P_W'(pp_ll_q);

  always_ff @(posedge clk_i) begin
    if (en_i.sum) begin
      p_q <= p_d;
    end
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

@@ design/hmi_sat.sv @@
`default_nettype none

// Rescales an exact polynomial value from DEG * IN_FRAC_BITS fraction bits
// to OUT_FRAC_BITS and saturates it to the signed result width.
module hmi_sat #(
  parameter int VAL_W         = 33,
  parameter int DEG           = 1,
  parameter int IN_FRAC_BITS  = hmi_pkg::IN_FRAC_DEFAULT,
  parameter int OUT_FRAC_BITS = hmi_pkg::OUT_FRAC_DEFAULT
) (
  input  logic signed [VAL_W-1:0]          val_i,
  output logic signed [hmi_pkg::OUT_W-1:0] res_o
);

  localparam int OutW  = hmi_pkg::OUT_W;
  localparam int Shift = DEG * IN_FRAC_BITS - OUT_FRAC_BITS;
  localparam int LSH   = (Shift < 0) ? -Shift : 0;
  localparam int RSH   = (Shift > 0) ? Shift : 0;
  localparam int XW    = (VAL_W + LSH > OutW + 1) ? VAL_W + LSH : OutW + 1;

  logic signed [XW-1:0]   ext;
  logic signed [XW-1:0]   scl;
  logic [XW-OutW:0]       top;
  logic                   in_range;

  // Surplus fraction bits drop with an arithmetic shift (toward minus infinity).
  assign ext = XW'(val_i);
  assign scl = (ext <<< LSH) >>> RSH;

  // The value fits when every bit above the result's sign equals that sign.
  assign top      = scl[XW-1:OutW-1];
  assign in_range = (&top) | ~(|top);

  always_comb begin
    if (in_range) begin
      res_o = scl[OutW-1:0];
    end else if (scl[XW-1]) begin
      res_o = {1'b1, {(OutW-1){1'b0}}};
    end else begin
      res_o = {1'b0, {(OutW-1){1'b1}}};
    end
  end

endmodule

`default_nettype wire

@@ design/hu_moment_invariants.sv @@
`default_nettype none

// Moment invariants: takes one set of seven normalized central moments
// (eta_20, eta_02, eta_11, eta_30, eta_12, eta_21, eta_03, signed Q2.30 by
// default) on the input channel and returns ten invariants (inv_1..inv_10,
// signed Q8.56 by default, saturated) on the output channel.
// A request moves on a channel at a rising edge where valid is high and
// stall is low. The block keeps no state between requests.
// Throughput is one request per cycle while the output is not stalled:
// seven register stages (adds, products of two narrow operands, adds,
// split wide products over two stages, final sums, rescale and saturation)
// each take a new request every cycle.
// When the receiver stalls, the result holds on the output and the stages
// behind it keep filling until all seven hold a request; only then does
// the input stall. Empty stages are squeezed out.
// Reset clears all stage valid bits, so no result is shown after reset.
module hu_moment_invariants #(
  parameter int IN_FRAC_BITS  = hmi_pkg::IN_FRAC_DEFAULT,
  parameter int OUT_FRAC_BITS = hmi_pkg::OUT_FRAC_DEFAULT
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic signed [hmi_pkg::IN_W-1:0]  eta_20_i,
  input  logic signed [hmi_pkg::IN_W-1:0]  eta_02_i,
  input  logic signed [hmi_pkg::IN_W-1:0]  eta_11_i,
  input  logic signed [hmi_pkg::IN_W-1:0]  eta_30_i,
  input  logic signed [hmi_pkg::IN_W-1:0]  eta_12_i,
  input  logic signed [hmi_pkg::IN_W-1:0]  eta_21_i,
  input  logic signed [hmi_pkg::IN_W-1:0]  eta_03_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic signed [hmi_pkg::OUT_W-1:0] inv_1_o,
  output logic signed [hmi_pkg::OUT_W-1:0] inv_2_o,
  output logic signed [hmi_pkg::OUT_W-1:0] inv_3_o,
  output logic signed [hmi_pkg::OUT_W-1:0] inv_4_o,
  output logic signed [hmi_pkg::OUT_W-1:0] inv_5_o,
  output logic signed [hmi_pkg::OUT_W-1:0] inv_6_o,
  output logic signed [hmi_pkg::OUT_W-1:0] inv_7_o,
  output logic signed [hmi_pkg::OUT_W-1:0] inv_8_o,
  output logic signed [hmi_pkg::OUT_W-1:0] inv_9_o,
  output logic signed [hmi_pkg::OUT_W-1:0] inv_10_o
);

  localparam int Stages = 7;
  localparam int IW     = hmi_pkg::IN_W;
  localparam int OW     = hmi_pkg::OUT_W;
  localparam int W1     = IW + 1;          // sum of two moments
  localparam int WA     = IW + 3;          // moment minus three times another
  localparam int WQ     = 2 * IW;          // product of two moments
  localparam int WP     = WQ + 1;          // difference of two such products
  localparam int WSQ    = 2 * W1;          // square of a sum
  localparam int WUV    = WSQ + 3;         // s^2 - 3 t^2 and 3 s^2 - t^2
  localparam int WW     = WSQ + 1;         // s^2 - t^2
  localparam int WAS    = WA + W1;         // a s and b t
  localparam int P5     = WAS + WUV;       // wide products of inv_5
  localparam int P6A    = W1 + WW;         // dif (s^2 - t^2)
  localparam int P6B    = WP + W1;         // eta_11 s t
  localparam int P9     = IW + WP;         // products of inv_9
  localparam int P10    = 2 * WP;          // products of inv_10
  localparam int WI2    = WSQ + 1;
  localparam int WI3    = 2 * WA + 1;
  localparam int WI7    = WQ + 1;
  localparam int WI8    = WQ + 2;
  localparam int WI5    = P5 + 1;
  localparam int WI6    = P6A + 1;
  localparam int WI9    = P9 + 2;
  localparam int WI10   = P10 + 3;

  // ---------------------------------------------------------------------
  // Pipeline control: a stage loads when it is empty or its request moves on.
  // ---------------------------------------------------------------------
  logic [Stages-1:0] vld_q, vld_d, en;
  hmi_pkg::mul_en_t  mul_en;

  always_comb begin
    en[Stages-1] = !vld_q[Stages-1] || !out_stall_i;
    for (int k = Stages - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  assign vld_d = {vld_q[Stages-2:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= (vld_q & ~en) | (vld_d & en);
    end
  end

  assign in_stall_o  = !en[0];
  assign out_valid_o = vld_q[Stages-1];
  assign mul_en.pp   = en[3];
  assign mul_en.sum  = en[4];

  // ---------------------------------------------------------------------
  // Stage 1: sums and differences of the input moments.
  // ---------------------------------------------------------------------
  logic signed [W1-1:0] s1_sum_d, s1_sum_q, s1_dif_d, s1_dif_q;
  logic signed [W1-1:0] s1_s_d, s1_s_q, s1_t_d, s1_t_q;
  logic signed [WA-1:0] s1_a_d, s1_a_q, s1_b_d, s1_b_q;
  logic signed [IW-1:0] s1_e20_q, s1_e02_q, s1_e11_q;
  logic signed [IW-1:0] s1_e30_q, s1_e12_q, s1_e21_q, s1_e03_q;

  assign s1_sum_d = W1'(eta_20_i) + W1'(eta_02_i);
  assign s1_dif_d = W1'(eta_20_i) - W1'(eta_02_i);
  assign s1_a_d   = WA'(eta_30_i) - (WA'(eta_12_i) <<< 1) - WA'(eta_12_i);
  assign s1_b_d   = (WA'(eta_21_i) <<< 1) + WA'(eta_21_i) - WA'(eta_03_i);
  assign s1_s_d   = W1'(eta_30_i) + W1'(eta_12_i);
  assign s1_t_d   = W1'(eta_21_i) + W1'(eta_03_i);

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      s1_sum_q <= s1_sum_d;
      s1_dif_q <= s1_dif_d;
      s1_a_q   <= s1_a_d;
      s1_b_q   <= s1_b_d;
      s1_s_q   <= s1_s_d;
      s1_t_q   <= s1_t_d;
      s1_e20_q <= eta_20_i;
      s1_e02_q <= eta_02_i;
      s1_e11_q <= eta_11_i;
      s1_e30_q <= eta_30_i;
      s1_e12_q <= eta_12_i;
      s1_e21_q <= eta_21_i;
      s1_e03_q <= eta_03_i;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: all products of two narrow operands.
  // ---------------------------------------------------------------------
  logic signed [WSQ-1:0]    s2_ss_d, s2_ss_q, s2_tt_d, s2_tt_q, s2_dd_d, s2_dd_q;
  logic signed [WQ-1:0]     s2_q12_d, s2_q12_q, s2_q21_d, s2_q21_q;
  logic signed [WQ-1:0]     s2_x3012_d, s2_x3012_q, s2_x2103_d, s2_x2103_q;
  logic signed [WQ-1:0]     s2_x3003_d, s2_x3003_q, s2_x2112_d, s2_x2112_q;
  logic signed [WQ-1:0]     s2_q11_d, s2_q11_q, s2_x2002_d, s2_x2002_q;
  logic signed [2*WA-1:0]   s2_aa_d, s2_aa_q, s2_bb_d, s2_bb_q;
  logic signed [WAS-1:0]    s2_as_d, s2_as_q, s2_bt_d, s2_bt_q;
  logic signed [WP-1:0]     s2_e11s_d, s2_e11s_q;
  logic signed [W1-1:0]     s2_sum_q, s2_dif_q, s2_t_q;
  logic signed [IW-1:0]     s2_e20_q, s2_e02_q, s2_e11_q;

  assign s2_ss_d    = s1_s_q * s1_s_q;
  assign s2_tt_d    = s1_t_q * s1_t_q;
  assign s2_dd_d    = s1_dif_q * s1_dif_q;
  assign s2_q12_d   = s1_e12_q * s1_e12_q;
  assign s2_q21_d   = s1_e21_q * s1_e21_q;
  assign s2_x3012_d = s1_e30_q * s1_e12_q;
  assign s2_x2103_d = s1_e21_q * s1_e03_q;
  assign s2_x3003_d = s1_e30_q * s1_e03_q;
  assign s2_x2112_d = s1_e21_q * s1_e12_q;
  assign s2_q11_d   = s1_e11_q * s1_e11_q;
  assign s2_x2002_d = s1_e20_q * s1_e02_q;
  assign s2_aa_d    = s1_a_q * s1_a_q;
  assign s2_bb_d    = s1_b_q * s1_b_q;
  assign s2_as_d    = s1_a_q * s1_s_q;
  assign s2_bt_d    = s1_b_q * s1_t_q;
  assign s2_e11s_d  = s1_e11_q * s1_s_q;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      s2_ss_q    <= s2_ss_d;
      s2_tt_q    <= s2_tt_d;
      s2_dd_q    <= s2_dd_d;
      s2_q12_q   <= s2_q12_d;
      s2_q21_q   <= s2_q21_d;
      s2_x3012_q <= s2_x3012_d;
      s2_x2103_q <= s2_x2103_d;
      s2_x3003_q <= s2_x3003_d;
      s2_x2112_q <= s2_x2112_d;
      s2_q11_q   <= s2_q11_d;
      s2_x2002_q <= s2_x2002_d;
      s2_aa_q    <= s2_aa_d;
      s2_bb_q    <= s2_bb_d;
      s2_as_q    <= s2_as_d;
      s2_bt_q    <= s2_bt_d;
      s2_e11s_q  <= s2_e11s_d;
      s2_sum_q   <= s1_sum_q;
      s2_dif_q   <= s1_dif_q;
      s2_t_q     <= s1_t_q;
      s2_e20_q   <= s1_e20_q;
      s2_e02_q   <= s1_e02_q;
      s2_e11_q   <= s1_e11_q;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3: quadratic invariants and the factors of the wide products.
  // ---------------------------------------------------------------------
  logic signed [WI2-1:0]  s3_inv2_d, s3_inv2_q, s3_inv4_d, s3_inv4_q;
  logic signed [WI3-1:0]  s3_inv3_d, s3_inv3_q;
  logic signed [WI7-1:0]  s3_inv7_d, s3_inv7_q;
  logic signed [WI8-1:0]  s3_inv8_d, s3_inv8_q;
  logic signed [WUV-1:0]  s3_u_d, s3_u_q, s3_v_d, s3_v_q;
  logic signed [WW-1:0]   s3_w_d, s3_w_q;
  logic signed [WP-1:0]   s3_p_d, s3_p_q, s3_r_d, s3_r_q, s3_dx_d, s3_dx_q;
  logic signed [WAS-1:0]  s3_as_q, s3_bt_q;
  logic signed [WP-1:0]   s3_e11s_q;
  logic signed [W1-1:0]   s3_sum_q, s3_dif_q, s3_t_q;
  logic signed [IW-1:0]   s3_e20_q, s3_e02_q, s3_e11_q;

  assign s3_inv2_d = WI2'(s2_dd_q) + (WI2'(s2_q11_q) <<< 2);
  assign s3_inv3_d = WI3'(s2_aa_q) + WI3'(s2_bb_q);
  assign s3_inv4_d = WI2'(s2_ss_q) + WI2'(s2_tt_q);
  assign s3_inv7_d = WI7'(s2_x2002_q) - WI7'(s2_q11_q);
  assign s3_inv8_d = WI8'(s2_x3012_q) + WI8'(s2_x2103_q)
                   - WI8'(s2_q12_q) - WI8'(s2_q21_q);
  assign s3_u_d    = WUV'(s2_ss_q) - (WUV'(s2_tt_q) <<< 1) - WUV'(s2_tt_q);
  assign s3_v_d    = (WUV'(s2_ss_q) <<< 1) + WUV'(s2_ss_q) - WUV'(s2_tt_q);
  assign s3_w_d    = WW'(s2_ss_q) - WW'(s2_tt_q);
  assign s3_p_d    = WP'(s2_x3012_q) - WP'(s2_q21_q);
  assign s3_r_d    = WP'(s2_x2103_q) - WP'(s2_q12_q);
  assign s3_dx_d   = WP'(s2_x3003_q) - WP'(s2_x2112_q);

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      s3_inv2_q <= s3_inv2_d;
      s3_inv3_q <= s3_inv3_d;
      s3_inv4_q <= s3_inv4_d;
      s3_inv7_q <= s3_inv7_d;
      s3_inv8_q <= s3_inv8_d;
      s3_u_q    <= s3_u_d;
      s3_v_q    <= s3_v_d;
      s3_w_q    <= s3_w_d;
      s3_p_q    <= s3_p_d;
      s3_r_q    <= s3_r_d;
      s3_dx_q   <= s3_dx_d;
      s3_as_q   <= s2_as_q;
      s3_bt_q   <= s2_bt_q;
      s3_e11s_q <= s2_e11s_q;
      s3_sum_q  <= s2_sum_q;
      s3_dif_q  <= s2_dif_q;
      s3_t_q    <= s2_t_q;
      s3_e20_q  <= s2_e20_q;
      s3_e02_q  <= s2_e02_q;
      s3_e11_q  <= s2_e11_q;
    end
  end

  // ---------------------------------------------------------------------
  // Stages 4 and 5: wide products in split multipliers.
  // ---------------------------------------------------------------------
  logic signed [P5-1:0]  m_asu, m_btv;
  logic signed [P6A-1:0] m_dw;
  logic signed [P6B-1:0] m_est;
  logic signed [P9-1:0]  m_er, m_ep, m_ed;
  logic signed [P10-1:0] m_dd, m_pr;

  hmi_wmul #(.A_W(WAS), .B_W(WUV)) u_mul_asu (
    .clk_i(clk_i), .en_i(mul_en), .a_i(s3_as_q), .b_i(s3_u_q), .p_o(m_asu)
  );
  hmi_wmul #(.A_W(WAS), .B_W(WUV)) u_mul_btv (
    .clk_i(clk_i), .en_i(mul_en), .a_i(s3_bt_q), .b_i(s3_v_q), .p_o(m_btv)
  );
  hmi_wmul #(.A_W(W1), .B_W(WW)) u_mul_dw (
    .clk_i(clk_i), .en_i(mul_en), .a_i(s3_dif_q), .b_i(s3_w_q), .p_o(m_dw)
  );
  hmi_wmul #(.A_W(WP), .B_W(W1)) u_mul_est (
    .clk_i(clk_i), .en_i(mul_en), .a_i(s3_e11s_q), .b_i(s3_t_q), .p_o(m_est)
  );
  hmi_wmul #(.A_W(IW), .B_W(WP)) u_mul_er (
    .clk_i(clk_i), .en_i(mul_en), .a_i(s3_e20_q), .b_i(s3_r_q), .p_o(m_er)
  );
  hmi_wmul #(.A_W(IW), .B_W(WP)) u_mul_ep (
    .clk_i(clk_i), .en_i(mul_en), .a_i(s3_e02_q), .b_i(s3_p_q), .p_o(m_ep)
  );
  hmi_wmul #(.A_W(IW), .B_W(WP)) u_mul_ed (
    .clk_i(clk_i), .en_i(mul_en), .a_i(s3_e11_q), .b_i(s3_dx_q), .p_o(m_ed)
  );
  hmi_wmul #(.A_W(WP), .B_W(WP)) u_mul_dd (
    .clk_i(clk_i), .en_i(mul_en), .a_i(s3_dx_q), .b_i(s3_dx_q), .p_o(m_dd)
  );
  hmi_wmul #(.A_W(WP), .B_W(WP)) u_mul_pr (
    .clk_i(clk_i), .en_i(mul_en), .a_i(s3_p_q), .b_i(s3_r_q), .p_o(m_pr)
  );

  // Finished invariants ride alongside the multipliers.
  logic signed [W1-1:0]  s4_sum_q, s5_sum_q;
  logic signed [WI2-1:0] s4_inv2_q, s5_inv2_q, s4_inv4_q, s5_inv4_q;
  logic signed [WI3-1:0] s4_inv3_q, s5_inv3_q;
  logic signed [WI7-1:0] s4_inv7_q, s5_inv7_q;
  logic signed [WI8-1:0] s4_inv8_q, s5_inv8_q;

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      s4_sum_q  <= s3_sum_q;
      s4_inv2_q <= s3_inv2_q;
      s4_inv3_q <= s3_inv3_q;
      s4_inv4_q <= s3_inv4_q;
      s4_inv7_q <= s3_inv7_q;
      s4_inv8_q <= s3_inv8_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      s5_sum_q  <= s4_sum_q;
      s5_inv2_q <= s4_inv2_q;
      s5_inv3_q <= s4_inv3_q;
      s5_inv4_q <= s4_inv4_q;
      s5_inv7_q <= s4_inv7_q;
      s5_inv8_q <= s4_inv8_q;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 6: sums of the wide products.
  // ---------------------------------------------------------------------
  logic signed [WI5-1:0]  s6_inv5_d, s6_inv5_q;
  logic signed [WI6-1:0]  s6_inv6_d, s6_inv6_q;
  logic signed [WI9-1:0]  s6_inv9_d, s6_inv9_q;
  logic signed [WI10-1:0] s6_inv10_d, s6_inv10_q;
  logic signed [W1-1:0]   s6_sum_q;
  logic signed [WI2-1:0]  s6_inv2_q, s6_inv4_q;
  logic signed [WI3-1:0]  s6_inv3_q;
  logic signed [WI7-1:0]  s6_inv7_q;
  logic signed [WI8-1:0]  s6_inv8_q;

  assign s6_inv5_d  = WI5'(m_asu) + WI5'(m_btv);
  assign s6_inv6_d  = WI6'(m_dw) + (WI6'(m_est) <<< 2);
  assign s6_inv9_d  = WI9'(m_er) + WI9'(m_ep) - WI9'(m_ed);
  assign s6_inv10_d = WI10'(m_dd) - (WI10'(m_pr) <<< 2);

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      s6_inv5_q  <= s6_inv5_d;
      s6_inv6_q  <= s6_inv6_d;
      s6_inv9_q  <= s6_inv9_d;
      s6_inv10_q <= s6_inv10_d;
      s6_sum_q   <= s5_sum_q;
      s6_inv2_q  <= s5_inv2_q;
      s6_inv3_q  <= s5_inv3_q;
      s6_inv4_q  <= s5_inv4_q;
      s6_inv7_q  <= s5_inv7_q;
      s6_inv8_q  <= s5_inv8_q;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 7: rescale to the output format, saturate, output register.
  // ---------------------------------------------------------------------
  logic signed [OW-1:0] r1, r2, r3, r4, r5, r6, r7, r8, r9, r10;
  logic signed [OW-1:0] inv1_q, inv2_q, inv3_q, inv4_q, inv5_q;
  logic signed [OW-1:0] inv6_q, inv7_q, inv8_q, inv9_q, inv10_q;

  hmi_sat #(.VAL_W(W1), .DEG(1), .IN_FRAC_BITS(IN_FRAC_BITS),
            .OUT_FRAC_BITS(OUT_FRAC_BITS)) u_sat_1 (.val_i(s6_sum_q), .res_o(r1));
  hmi_sat #(.VAL_W(WI2), .DEG(2), .IN_FRAC_BITS(IN_FRAC_BITS),
            .OUT_FRAC_BITS(OUT_FRAC_BITS)) u_sat_2 (.val_i(s6_inv2_q), .res_o(r2));
  hmi_sat #(.VAL_W(WI3), .DEG(2), .IN_FRAC_BITS(IN_FRAC_BITS),
            .OUT_FRAC_BITS(OUT_FRAC_BITS)) u_sat_3 (.val_i(s6_inv3_q), .res_o(r3));
  hmi_sat #(.VAL_W(WI2), .DEG(2), .IN_FRAC_BITS(IN_FRAC_BITS),
            .OUT_FRAC_BITS(OUT_FRAC_BITS)) u_sat_4 (.val_i(s6_inv4_q), .res_o(r4));
  hmi_sat #(.VAL_W(WI5), .DEG(4), .IN_FRAC_BITS(IN_FRAC_BITS),
            .OUT_FRAC_BITS(OUT_FRAC_BITS)) u_sat_5 (.val_i(s6_inv5_q), .res_o(r5));
  hmi_sat #(.VAL_W(WI6), .DEG(3), .IN_FRAC_BITS(IN_FRAC_BITS),
            .OUT_FRAC_BITS(OUT_FRAC_BITS)) u_sat_6 (.val_i(s6_inv6_q), .res_o(r6));
  hmi_sat #(.VAL_W(WI7), .DEG(2), .IN_FRAC_BITS(IN_FRAC_BITS),
            .OUT_FRAC_BITS(OUT_FRAC_BITS)) u_sat_7 (.val_i(s6_inv7_q), .res_o(r7));
  hmi_sat #(.VAL_W(WI8), .DEG(2), .IN_FRAC_BITS(IN_FRAC_BITS),
            .OUT_FRAC_BITS(OUT_FRAC_BITS)) u_sat_8 (.val_i(s6_inv8_q), .res_o(r8));
  hmi_sat #(.VAL_W(WI9), .DEG(3), .IN_FRAC_BITS(IN_FRAC_BITS),
            .OUT_FRAC_BITS(OUT_FRAC_BITS)) u_sat_9 (.val_i(s6_inv9_q), .res_o(r9));
  hmi_sat #(.VAL_W(WI10), .DEG(4), .IN_FRAC_BITS(IN_FRAC_BITS),
            .OUT_FRAC_BITS(OUT_FRAC_BITS)) u_sat_10 (.val_i(s6_inv10_q), .res_o(r10));

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      inv1_q  <= r1;
      inv2_q  <= r2;
      inv3_q  <= r3;
      inv4_q  <= r4;
      inv5_q  <= r5;
      inv6_q  <= r6;
      inv7_q  <= r7;
      inv8_q  <= r8;
      inv9_q  <= r9;
      inv10_q <= r10;
    end
  end

  assign inv_1_o  = inv1_q;
  assign inv_2_o  = inv2_q;
  assign inv_3_o  = inv3_q;
  assign inv_4_o  = inv4_q;
  assign inv_5_o  = inv5_q;
  assign inv_6_o  = inv6_q;
  assign inv_7_o  = inv7_q;
  assign inv_8_o  = inv8_q;
  assign inv_9_o  = inv9_q;
  assign inv_10_o = inv10_q;

`ifndef NO_ASSERTIONS
  // The input stalls only when every stage holds a request.
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (&vld_q))
    else $error("input stalled while a pipeline stage is empty");

  // Back pressure comes only from the receiver.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_stall_i)
    else $error("input stalled without a stalled receiver");

  // An accepted request always lands in the first stage.
  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> vld_q[0])
    else $error("accepted request missing from the first stage");

  // Without an accepted request the number of requests in flight never grows.
  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_valid_i && !in_stall_o) |=> ($countones(vld_q) <= $countones($past(vld_q))))
    else $error("request appeared in the pipeline without an input");
`endif

endmodule

`default_nettype wire
